// ----- rtl/core/ssc_pkg.sv -----
package ssc_pkg;

	localparam int QW      = 32;
	localparam int DW      = 2 * QW;
	localparam int RT      = 32;
	localparam int NORM_FB = 30;

	typedef struct packed {
		logic             rz;
		logic [2:0]       cneg;
		logic [2:0][31:0] ca;
	} cont_sb_t;

	typedef struct packed {
		logic             hit;
		logic             mxz;
		logic [2:0]       neg;
		logic [2:0][30:0] ms;
	} root_sb_t;

	typedef struct packed {
		logic       hit;
		logic       mxz;
		logic [2:0] neg;
	} norm_sb_t;

endpackage

// ----- rtl/core/ssc_div.sv -----
module ssc_div import ssc_pkg::*; #(
	parameter int SB = 1
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [2:0][DW-1:0]   num,
	input  logic [QW-1:0]        den,
	input  logic [SB-1:0]        sb_in,
	output logic [2:0][QW-1:0]   quo,
	output logic [SB-1:0]        sb_out
);

	logic [2:0][QW-1:0] rem_s [QW+1];
	logic [2:0][QW-1:0] low_s [QW+1];
	logic [2:0][QW-1:0] quo_s [QW+1];
	logic [QW-1:0]      den_s [QW+1];
	logic [SB-1:0]      sb_s  [QW+1];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			rem_s[0][l] = num[l][DW-1:QW];
			low_s[0][l] = num[l][QW-1:0];
			quo_s[0][l] = '0;
		end
		den_s[0] = den;
		sb_s[0]  = sb_in;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [2:0][QW:0] trial;
		logic [2:0]       ge;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				trial[l] = {rem_s[k][l], low_s[k][l][QW-1]};
				ge[l]    = trial[l] >= {1'b0, den_s[k]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					rem_s[k+1][l] <= ge[l] ? QW'(trial[l] - {1'b0, den_s[k]})
					                       : trial[l][QW-1:0];
					low_s[k+1][l] <= {low_s[k][l][QW-2:0], 1'b0};
					quo_s[k+1][l] <= {quo_s[k][l][QW-2:0], ge[l]};
				end
				den_s[k+1] <= den_s[k];
				sb_s[k+1]  <= sb_s[k];
			end
		end
	end

	assign quo    = quo_s[QW];
	assign sb_out = sb_s[QW];

endmodule

// ----- rtl/core/ssc_sqrt.sv -----
module ssc_sqrt import ssc_pkg::*; #(
	parameter int SB = 1
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RT-1:0] rad,
	input  logic [SB-1:0]   sb_in,
	output logic [RT-1:0]   root,
	output logic [SB-1:0]   sb_out
);

	logic [2*RT-1:0] rad_s  [RT+1];
	logic [RT+1:0]   rem_s  [RT+1];
	logic [RT-1:0]   root_s [RT+1];
	logic [SB-1:0]   sb_s   [RT+1];

	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign sb_s[0]   = sb_in;

	for (genvar k = 0; k < RT; k++) begin : g_step
		logic [RT+3:0] shv;
		logic [RT+3:0] trial;
		logic          ge;

		assign shv   = {rem_s[k], rad_s[k][2*RT-1:2*RT-2]};
		assign trial = {2'b00, root_s[k], 2'b01};
		assign ge    = shv >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= {rad_s[k][2*RT-3:0], 2'b00};
				rem_s[k+1]  <= ge ? (RT+2)'(shv - trial) : shv[RT+1:0];
				root_s[k+1] <= {root_s[k][RT-2:0], ge};
				sb_s[k+1]   <= sb_s[k];
			end
		end
	end

	assign root   = root_s[RT];
	assign sb_out = sb_s[RT];

endmodule

// ----- rtl/core/sphere_sphere_contact.sv -----
// channel  | handshake           | payload
// in       | in_valid/in_stall   | center_a_*, radius_a, center_b_*, radius_b
// out      | out_valid/out_stall | hit, contact_*, normal_*
//
// One beat per cycle unless a stalled output freezes the pipeline; its depth is set by the
// 32-step square root followed by the 32-step normal divider.
// arst_n clears the valid bits only; data registers are not reset.
// A stalled output beat freezes every stage; in_stall follows it.
module sphere_sphere_contact import ssc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] center_a_x,
	input  logic signed [31:0] center_a_y,
	input  logic signed [31:0] center_a_z,
	input  logic [30:0]        radius_a,
	input  logic signed [31:0] center_b_x,
	input  logic signed [31:0] center_b_y,
	input  logic signed [31:0] center_b_z,
	input  logic [30:0]        radius_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic signed [31:0] contact_x,
	output logic signed [31:0] contact_y,
	output logic signed [31:0] contact_z,
	output logic signed [31:0] normal_x,
	output logic signed [31:0] normal_y,
	output logic signed [31:0] normal_z
);

	localparam int CDIV_IN = 3;
	localparam int ROOT_IN = 7;
	localparam int NDIV_IN = ROOT_IN + RT + 1;
	localparam int LAST    = NDIV_IN + QW;
	localparam int CDLY    = LAST - (CDIV_IN + QW);
	localparam int LAT     = LAST + 1;

	logic              adv;
	logic [LAT-1:0]    vld_q;
	logic [2:0][31:0]  ca, cb;

	assign ca = {center_a_z, center_a_y, center_a_x};
	assign cb = {center_b_z, center_b_y, center_b_x};

	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// stage 1
	logic [2:0][32:0] d_s1;
	logic [2:0][63:0] pa_s1, pb_s1;
	logic [2:0][31:0] ca_s1;
	logic [31:0]      rsum_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= $signed({cb[i][31], cb[i]}) - $signed({ca[i][31], ca[i]});
				pa_s1[i] <= $signed(ca[i]) * $signed({1'b0, radius_a});
				pb_s1[i] <= $signed(cb[i]) * $signed({1'b0, radius_b});
			end
			ca_s1   <= ca;
			rsum_s1 <= {1'b0, radius_a} + {1'b0, radius_b};
		end
	end

	// stage 2
	logic [2:0][31:0] m_s2, ca_s2;
	logic [2:0]       neg_s2;
	logic [2:0][63:0] num_s2;
	logic [31:0]      rsum_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				m_s2[i]   <= d_s1[i][32] ? 32'(33'd0 - d_s1[i]) : d_s1[i][31:0];
				neg_s2[i] <= d_s1[i][32];
				num_s2[i] <= pa_s1[i] + pb_s1[i];
			end
			ca_s2   <= ca_s1;
			rsum_s2 <= rsum_s1;
		end
	end

	// stage 3
	logic [2:0][63:0] sq_s3, cdiv_s3;
	logic [63:0]      rsq_s3;
	logic [31:0]      mx_s3, rsum_s3;
	logic [2:0][31:0] m_s3;
	logic [2:0]       neg_s3;
	cont_sb_t         csb_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i]       <= m_s2[i] * m_s2[i];
				cdiv_s3[i]     <= (num_s2[i][63] ? 64'd0 - num_s2[i] : num_s2[i])
				                  + {33'd0, rsum_s2[31:1]};
				csb_s3.cneg[i] <= num_s2[i][63];
			end
			rsq_s3    <= rsum_s2 * rsum_s2;
			mx_s3     <= (m_s2[0] > m_s2[1])
			             ? ((m_s2[0] > m_s2[2]) ? m_s2[0] : m_s2[2])
			             : ((m_s2[1] > m_s2[2]) ? m_s2[1] : m_s2[2]);
			m_s3      <= m_s2;
			neg_s3    <= neg_s2;
			rsum_s3   <= rsum_s2;
			csb_s3.ca <= ca_s2;
			csb_s3.rz <= rsum_s2 == '0;
		end
	end

	logic [2:0][QW-1:0] cq_a;
	cont_sb_t           csb_a;

	ssc_div #(.SB($bits(cont_sb_t))) u_cdiv (
		.clk    (clk),
		.en     (adv),
		.num    (cdiv_s3),
		.den    (rsum_s3),
		.sb_in  (csb_s3),
		.quo    (cq_a),
		.sb_out (csb_a)
	);

	// stage 4
	logic [65:0]      sum_s4;
	logic [63:0]      rsq_s4;
	logic             big_s4, mxz_s4;
	logic [4:0]       sh_s4;
	logic [2:0][31:0] m_s4;
	logic [2:0]       neg_s4;
	logic [4:0]       sh_c;

	always_comb begin
		sh_c = '0;
		for (int k = 0; k < 31; k++) begin
			if (mx_s3[k]) begin
				sh_c = 5'(30 - k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s4 <= {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};
			rsq_s4 <= rsq_s3;
			big_s4 <= mx_s3[31];
			mxz_s4 <= mx_s3 == '0;
			sh_s4  <= sh_c;
			m_s4   <= m_s3;
			neg_s4 <= neg_s3;
		end
	end

	// stage 5
	root_sb_t rsb_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			rsb_s5.hit <= {2'b00, rsq_s4} >= sum_s4;
			rsb_s5.mxz <= mxz_s4;
			rsb_s5.neg <= neg_s4;
			for (int i = 0; i < 3; i++) begin
				rsb_s5.ms[i] <= big_s4 ? m_s4[i][31:1] : 31'(m_s4[i] << sh_s4);
			end
		end
	end

	// stage 6
	logic [2:0][61:0] sq2_s6;
	root_sb_t         rsb_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq2_s6[i] <= rsb_s5.ms[i] * rsb_s5.ms[i];
			end
			rsb_s6 <= rsb_s5;
		end
	end

	// stage 7
	logic [2*RT-1:0] s2_s7;
	root_sb_t        rsb_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			s2_s7  <= {2'b00, sq2_s6[0]} + {2'b00, sq2_s6[1]} + {2'b00, sq2_s6[2]};
			rsb_s7 <= rsb_s6;
		end
	end

	logic [RT-1:0] len_a;
	root_sb_t      rsb_a;

	ssc_sqrt #(.SB($bits(root_sb_t))) u_sqrt (
		.clk    (clk),
		.en     (adv),
		.rad    (s2_s7),
		.sb_in  (rsb_s7),
		.root   (len_a),
		.sb_out (rsb_a)
	);

	// normal dividend
	logic [2:0][DW-1:0] nd_s40;
	logic [QW-1:0]      len_s40;
	norm_sb_t           nsb_s40;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				nd_s40[i] <= DW'({rsb_a.ms[i], {NORM_FB{1'b0}}}) + DW'(len_a >> 1);
			end
			len_s40     <= QW'(len_a);
			nsb_s40.hit <= rsb_a.hit;
			nsb_s40.mxz <= rsb_a.mxz;
			nsb_s40.neg <= rsb_a.neg;
		end
	end

	logic [2:0][QW-1:0] nq_a;
	norm_sb_t           nsb_a;

	ssc_div #(.SB($bits(norm_sb_t))) u_ndiv (
		.clk    (clk),
		.en     (adv),
		.num    (nd_s40),
		.den    (len_s40),
		.sb_in  (nsb_s40),
		.quo    (nq_a),
		.sb_out (nsb_a)
	);

	// contact results wait for the normal path
	logic [2:0][QW-1:0] cq_dly [CDLY];
	cont_sb_t           csb_dly [CDLY];

	always_ff @(posedge clk) begin
		if (adv) begin
			cq_dly[0]  <= cq_a;
			csb_dly[0] <= csb_a;
			for (int k = 1; k < CDLY; k++) begin
				cq_dly[k]  <= cq_dly[k-1];
				csb_dly[k] <= csb_dly[k-1];
			end
		end
	end

	// output register
	logic             hit_q;
	logic [2:0][31:0] contact_q, normal_q;
	cont_sb_t         csb_l;
	logic [2:0][31:0] cq_l;

	assign csb_l = csb_dly[CDLY-1];
	assign cq_l  = cq_dly[CDLY-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q <= nsb_a.hit;
			for (int i = 0; i < 3; i++) begin
				if (!nsb_a.hit) begin
					contact_q[i] <= '0;
				end else if (csb_l.rz) begin
					contact_q[i] <= csb_l.ca[i];
				end else begin
					contact_q[i] <= csb_l.cneg[i] ? 32'd0 - cq_l[i] : cq_l[i];
				end
				if (!nsb_a.hit || nsb_a.mxz) begin
					normal_q[i] <= '0;
				end else begin
					normal_q[i] <= nsb_a.neg[i] ? 32'd0 - nq_a[i] : nq_a[i];
				end
			end
		end
	end

	assign hit       = hit_q;
	assign contact_x = contact_q[0];
	assign contact_y = contact_q[1];
	assign contact_z = contact_q[2];
	assign normal_x  = normal_q[0];
	assign normal_y  = normal_q[1];
	assign normal_z  = normal_q[2];

endmodule

// ----- test/sphere_sphere_contact_check.sv -----
`timescale 1ns / 100ps
module sphere_sphere_contact_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] center_a_x,
	input  logic signed [31:0] center_a_y,
	input  logic signed [31:0] center_a_z,
	input  logic [30:0]        radius_a,
	input  logic signed [31:0] center_b_x,
	input  logic signed [31:0] center_b_y,
	input  logic signed [31:0] center_b_z,
	input  logic [30:0]        radius_b,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               hit,
	input  logic signed [31:0] contact_x,
	input  logic signed [31:0] contact_y,
	input  logic signed [31:0] contact_z,
	input  logic signed [31:0] normal_x,
	input  logic signed [31:0] normal_y,
	input  logic signed [31:0] normal_z,
	output int                 errors,
	output int                 pending,
	output int                 hits_seen
);

	typedef struct packed {
		logic             hit;
		logic [2:0][31:0] pt;
		logic [2:0][31:0] nrm;
	} contact_t;

	contact_t contacts_due [4096];
	int       wr_n, rd_n;

	function automatic logic [63:0] int_sqrt(logic [127:0] v);
		logic [63:0] r;
		logic [127:0] t;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t[63:0];
		end
		return r;
	endfunction

	function automatic contact_t sphere_contact(logic signed [31:0] ax, ay, az,
			logic [30:0] ra, logic signed [31:0] bx, by, bz, logic [30:0] rb);
		contact_t res;
		logic signed [63:0] ca[3], cb[3], d[3];
		logic [63:0] mg[3];
		logic [63:0] mx, rsum, len, q, num_m;
		logic [127:0] sumsq, s2;
		logic signed [127:0] num;
		int sh;
		res = '0;
		ca[0] = ax; ca[1] = ay; ca[2] = az;
		cb[0] = bx; cb[1] = by; cb[2] = bz;
		rsum = 64'(ra) + 64'(rb);
		mx = 0;
		sumsq = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = cb[i] - ca[i];
			mg[i] = d[i] < 0 ? -d[i] : d[i];
			if (mg[i] > mx)
				mx = mg[i];
			sumsq += 128'(mg[i]) * 128'(mg[i]);
		end
		if (sumsq > 128'(rsum) * 128'(rsum))
			return res;
		res.hit = 1;
		for (int i = 0; i < 3; i++) begin
			if (rsum == 0) begin
				res.pt[i] = ca[i][31:0];
			end else begin
				num = 128'(ca[i]) * $signed(128'(ra)) + 128'(cb[i]) * $signed(128'(rb));
				num_m = num < 0 ? 64'(-num) : 64'(num);
				q = (num_m + rsum / 2) / rsum;
				res.pt[i] = num < 0 ? -q[31:0] : q[31:0];
			end
		end
		if (mx != 0) begin
			if (mx >= 64'h8000_0000) begin
				for (int i = 0; i < 3; i++)
					mg[i] = mg[i] >> 1;
			end else begin
				sh = 0;
				while ((mx << sh) < 64'h4000_0000)
					sh++;
				for (int i = 0; i < 3; i++)
					mg[i] = mg[i] << sh;
			end
			s2 = 0;
			for (int i = 0; i < 3; i++)
				s2 += 128'(mg[i]) * 128'(mg[i]);
			len = int_sqrt(s2);
			for (int i = 0; i < 3; i++) begin
				q = 64'((128'(mg[i]) * 128'h4000_0000 + 128'(len / 2)) / 128'(len));
				res.nrm[i] = d[i] < 0 ? -q[31:0] : q[31:0];
			end
		end
		return res;
	endfunction

	function automatic int cmp(string nm, logic [31:0] e, logic [31:0] a);
		if (e === a)
			return 0;
		$display("%0t mismatch %s expected %h actual %h", $time, nm, e, a);
		return 1;
	endfunction

	contact_t e;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors <= 0;
			hits_seen <= 0;
			wr_n <= 0;
			rd_n <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				contacts_due[wr_n[11:0]] <= sphere_contact(center_a_x, center_a_y,
					center_a_z, radius_a, center_b_x, center_b_y, center_b_z, radius_b);
				wr_n <= wr_n + 1;
			end
			if (out_valid && !out_stall) begin
				if (rd_n == wr_n) begin
					$display("%0t unexpected beat", $time);
					errors <= errors + 1;
				end else begin
					e = contacts_due[rd_n[11:0]];
					rd_n <= rd_n + 1;
					errors <= errors + cmp("hit", 32'(e.hit), 32'(hit))
						+ cmp("contact_x", e.pt[0], contact_x)
						+ cmp("contact_y", e.pt[1], contact_y)
						+ cmp("contact_z", e.pt[2], contact_z)
						+ cmp("normal_x", e.nrm[0], normal_x)
						+ cmp("normal_y", e.nrm[1], normal_y)
						+ cmp("normal_z", e.nrm[2], normal_z);
					hits_seen <= hits_seen + (hit === 1'b1);
				end
			end
		end
	end

	assign pending = wr_n - rd_n;

endmodule

// ----- test/sphere_sphere_contact_test.sv -----
`timescale 1ns / 100ps
module sphere_sphere_contact_test;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, out_stall = 0;
	logic in_stall, out_valid;
	logic signed [31:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0;
	logic [30:0] ra = 0, rb = 0;
	logic hit;
	logic signed [31:0] cx, cy, cz, nx, ny, nz;
	int errors, pending, hits_seen;
	int sent = 0, idle_cycles = 0;
	bit calm = 0;
	bit timed_out = 0;

	always #5 clk = ~clk;

	sphere_sphere_contact dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.center_a_x(ax), .center_a_y(ay), .center_a_z(az), .radius_a(ra),
		.center_b_x(bx), .center_b_y(by), .center_b_z(bz), .radius_b(rb),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit),
		.contact_x(cx), .contact_y(cy), .contact_z(cz),
		.normal_x(nx), .normal_y(ny), .normal_z(nz)
	);

	sphere_sphere_contact_check chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.center_a_x(ax), .center_a_y(ay), .center_a_z(az), .radius_a(ra),
		.center_b_x(bx), .center_b_y(by), .center_b_z(bz), .radius_b(rb),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit),
		.contact_x(cx), .contact_y(cy), .contact_z(cz),
		.normal_x(nx), .normal_y(ny), .normal_z(nz),
		.errors(errors), .pending(pending), .hits_seen(hits_seen)
	);

	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < 17);

	always @(posedge clk) begin
		if (!arst_n || ((in_valid && !in_stall) || (out_valid && !out_stall)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("FAIL sphere_sphere_contact");
			$finish;
		end
	end

	function automatic logic [31:0] rnd_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(4000)) - 2000;
			default: return $signed($urandom_range(32'h2_0000)) - 32'h1_0000;
		endcase
	endfunction

	task automatic send(logic [31:0] a0, a1, a2, int unsigned r0,
			logic [31:0] b0, b1, b2, int unsigned r1);
		while (!calm && $urandom_range(99) < 17) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		ax <= a0; ay <= a1; az <= a2; ra <= 31'(r0);
		bx <= b0; by <= b1; bz <= b2; rb <= 31'(r1);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_random();
		int mode;
		logic [31:0] a[3], b[3];
		logic [30:0] r0, r1;
		mode = $urandom_range(2);
		for (int i = 0; i < 3; i++) begin
			a[i] = rnd_coord(mode);
			b[i] = ($urandom_range(3) == 0) ? a[i] : a[i] + rnd_coord(mode);
		end
		case ($urandom_range(3))
			0: begin r0 = 31'($urandom); r1 = 31'($urandom); end
			1: begin r0 = 31'($urandom_range(3000)); r1 = 31'($urandom_range(3000)); end
			2: begin
				r0 = 31'($urandom_range(32'h3_0000));
				r1 = 31'($urandom_range(32'h3_0000));
			end
			default: begin r0 = 0; r1 = 31'($urandom_range(1)); end
		endcase
		send(a[0], a[1], a[2], r0, b[0], b[1], b[2], r1);
	endtask

	localparam logic [31:0] MAXP = 32'h7fff_ffff, MINN = 32'h8000_0000;
	localparam logic [30:0] RMAX = 31'h7fff_ffff;

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send(0, 0, 0, 0, 0, 0, 0, 0);
		send(5, -7, 9, 0, 5, -7, 9, 0);
		send(0, 0, 0, 1, 0, 0, 0, 0);
		send(MINN, MINN, MINN, RMAX, MAXP, MAXP, MAXP, RMAX);
		send(MAXP, MAXP, MAXP, RMAX, MINN, MINN, MINN, RMAX);
		send(MINN, 0, 0, RMAX, MAXP, 0, 0, RMAX);
		send(MINN, 0, 0, 0, MAXP, 0, 0, 0);
		send(0, 0, 0, 3, 3, 0, 0, 0);
		send(0, 0, 0, 3, 4, 0, 0, 0);
		send(0, 0, 0, 5, 3, 4, 0, 0);
		send(1, 2, 3, RMAX, -1, -2, -3, 1);
		send(-100, 50, 7, 60, 100, -50, -7, 80);
		send(0, 0, 0, 1, 0, 1, 1, 1);
		send(-3, -3, -3, 2, 3, 3, 3, 9);
		send(MAXP, MINN, 0, RMAX, MAXP, MINN, 1, 0);
		send(0, 0, 0, 1, 0, 0, -1, 0);
		in_valid <= 0;
		while (pending != 0)
			@(posedge clk);
		calm = 1;
		repeat (300) send_random();
		calm = 0;
		repeat (1100) send_random();
		in_valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("Sent %0d sphere pairs, %0d hits; directed extremes,", sent, hits_seen);
		$display("coincident and zero-radius cases with random gaps and output stalls.");
		if (errors == 0)
			$display("PASS sphere_sphere_contact");
		else
			$display("FAIL sphere_sphere_contact");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/ssc_pkg.sv
rtl/core/ssc_div.sv
rtl/core/ssc_sqrt.sv
rtl/core/sphere_sphere_contact.sv
test/sphere_sphere_contact_check.sv
test/sphere_sphere_contact_test.sv
